[hdl/aes128_key_expansion_unit_macros.svh]
// -----------------------------------------------------------------------------
// aes128_key_expansion_unit_macros.svh
// Assertion helper macros for the AES-128 key expansion unit.
// -----------------------------------------------------------------------------
`ifndef AES128_KEY_EXPANSION_UNIT_MACROS_SVH
`define AES128_KEY_EXPANSION_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define AESKX_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define AESKX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// delayed implication, disabled while in reset
`define AESKX_ASSERT_DLY2(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

[hdl/aeskx_pkg.sv]
// -----------------------------------------------------------------------------
// aeskx_pkg
// Shared types, constants and S-box/round-constant functions for the AES-128
// key expansion unit.
// -----------------------------------------------------------------------------
package aeskx_pkg;

  localparam int KEY_MATRIX_DIM = 4;
  localparam int WORD_W         = 32;
  localparam int HALF_W         = 64;
  localparam int ROUND_W        = 4;

  localparam logic [ROUND_W-1:0] FIRST_ROUND = 4'd1;
  localparam logic [ROUND_W-1:0] ROUND_COUNT = 4'd10;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [ROUND_W-1:0] round_t;

  // controller -> datapath
  typedef struct packed {
    logic   load_key;  // capture a new cipher key
    logic   step;      // produce the next round key into the output register
    round_t round;     // round being produced by step
  } cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // RotWord then SubWord
  function automatic word_t sub_rot_word(input word_t w);
    return {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

  // round constant, top byte of the word
  function automatic logic [7:0] rcon(input round_t rnd);
    logic [7:0] rc;
    unique case (rnd)
      4'd1:    rc = 8'h01;
      4'd2:    rc = 8'h02;
      4'd3:    rc = 8'h04;
      4'd4:    rc = 8'h08;
      4'd5:    rc = 8'h10;
      4'd6:    rc = 8'h20;
      4'd7:    rc = 8'h40;
      4'd8:    rc = 8'h80;
      4'd9:    rc = 8'h1b;
      4'd10:   rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

endpackage

[hdl/aeskx_datapath.sv]
// -----------------------------------------------------------------------------
// aeskx_datapath
// Key register, one-round expansion logic and the output word register.
// -----------------------------------------------------------------------------
module aeskx_datapath (
  input  logic                              clk,
  input  aeskx_pkg::cmd_t                   cmd,
  input  logic [aeskx_pkg::HALF_W-1:0]      key_hi,
  input  logic [aeskx_pkg::HALF_W-1:0]      key_lo,
  output logic [aeskx_pkg::ROUND_W-1:0]     round_number,
  output logic [aeskx_pkg::HALF_W-1:0]      round_key_hi,
  output logic [aeskx_pkg::HALF_W-1:0]      round_key_lo,
  output logic                              last_round
);

  aeskx_pkg::word_t key_r [aeskx_pkg::KEY_MATRIX_DIM];
  aeskx_pkg::word_t key_nxt [aeskx_pkg::KEY_MATRIX_DIM];
  aeskx_pkg::word_t rk_nxt [aeskx_pkg::KEY_MATRIX_DIM];

  logic [aeskx_pkg::ROUND_W-1:0] round_number_r;
  logic [aeskx_pkg::HALF_W-1:0]  round_key_hi_r;
  logic [aeskx_pkg::HALF_W-1:0]  round_key_lo_r;
  logic                          last_round_r;

  // next round key: word 0 gets the g() function, the rest chain through
  always_comb begin
    rk_nxt[0] = key_r[0] ^ aeskx_pkg::sub_rot_word(key_r[aeskx_pkg::KEY_MATRIX_DIM-1])
              ^ {aeskx_pkg::rcon(cmd.round), 24'h000000};
    for (int i = 1; i < aeskx_pkg::KEY_MATRIX_DIM; i++) begin
      rk_nxt[i] = key_r[i] ^ rk_nxt[i-1];
    end
  end

  always_comb begin
    if (cmd.load_key) begin
      key_nxt[0] = key_hi[63:32];
      key_nxt[1] = key_hi[31:0];
      key_nxt[2] = key_lo[63:32];
      key_nxt[3] = key_lo[31:0];
    end else if (cmd.step) begin
      key_nxt = rk_nxt;
    end else begin
      key_nxt = key_r;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (cmd.step) begin
      round_number_r <= cmd.round;
      round_key_hi_r <= {rk_nxt[0], rk_nxt[1]};
      round_key_lo_r <= {rk_nxt[2], rk_nxt[3]};
      last_round_r   <= (cmd.round == aeskx_pkg::ROUND_COUNT);
    end
  end

  assign round_number = round_number_r;
  assign round_key_hi = round_key_hi_r;
  assign round_key_lo = round_key_lo_r;
  assign last_round   = last_round_r;

endmodule

[hdl/aeskx_ctrl.sv]
// -----------------------------------------------------------------------------
// aeskx_ctrl
// Run state machine, round counter and output valid flag.
// -----------------------------------------------------------------------------
module aeskx_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output aeskx_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  aeskx_pkg::round_t round_r, round_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              advance;
  logic              accept;

  // output register free or being drained this cycle
  assign advance  = (state_r == ST_RUN) && (!out_valid_r || !out_stall);
  assign in_stall = !((state_r == ST_IDLE) ||
                      (advance && (round_r == aeskx_pkg::ROUND_COUNT)));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          round_nxt = aeskx_pkg::FIRST_ROUND;
        end
      end
      ST_RUN: begin
        if (accept) begin
          round_nxt = aeskx_pkg::FIRST_ROUND;
        end else if (advance) begin
          if (round_r == aeskx_pkg::ROUND_COUNT) begin
            state_nxt = ST_IDLE;
          end else begin
            round_nxt = round_r + 4'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= aeskx_pkg::FIRST_ROUND;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign cmd.load_key = accept;
  assign cmd.step     = advance;
  assign cmd.round    = round_r;

endmodule

[hdl/aes128_key_expansion_unit.sv]
// -----------------------------------------------------------------------------
// aes128_key_expansion_unit
// AES-128 key schedule: one cipher key in, round keys 1 to 10 out in order.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one 128-bit cipher key per word
//   as in_key_hi (bytes 0..7) and in_key_lo (bytes 8..15), byte 0 in the MSBs.
//   Output channel (out_valid / out_stall) returns ten words per key, each
//   with out_round_number 1..10, the round key halves and out_last_round set
//   on round 10. A word moves when valid is high and stall is low.
// Order: the key register loads at the accepting edge, then the expansion
//   step writes round 1 into the output register, from where it moves when
//   out_stall is low.
// Throughput: one round key per cycle while out_stall is low, from a single shared
//   expansion step (four S-box lookups plus an XOR chain); the next key is taken
//   in the cycle round 10 is produced, so keys follow back to back.
// Stall: while out_stall holds a word, expansion pauses and in_stall stays
//   high until round 10 has gone into the output register; nothing is
//   dropped or repeated.
// Reset: rst_n (synchronous, active low) clears the controller and the output
//   valid flag; key and round key registers are not reset.
// -----------------------------------------------------------------------------
`include "aes128_key_expansion_unit_macros.svh"

module aes128_key_expansion_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // cipher key in
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [aeskx_pkg::HALF_W-1:0]  in_key_hi,
  input  logic [aeskx_pkg::HALF_W-1:0]  in_key_lo,
  // round keys out
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [aeskx_pkg::ROUND_W-1:0] out_round_number,
  output logic [aeskx_pkg::HALF_W-1:0]  out_round_key_hi,
  output logic [aeskx_pkg::HALF_W-1:0]  out_round_key_lo,
  output logic                          out_last_round
);

  aeskx_pkg::cmd_t cmd;

  // sequencing: state, round count, output valid
  aeskx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // key register, expansion step, output payload register
  aeskx_datapath u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .key_hi       (in_key_hi),
    .key_lo       (in_key_lo),
    .round_number (out_round_number),
    .round_key_hi (out_round_key_hi),
    .round_key_lo (out_round_key_lo),
    .last_round   (out_last_round)
  );

  // last flag only ever rides on round 10
  `AESKX_ASSERT_IMPL(a_last_is_round10, clk, rst_n, out_valid && out_last_round, out_round_number == aeskx_pkg::ROUND_COUNT, "last flag on wrong round")

  // a taken key always shows output once the key and output registers have loaded
  `AESKX_ASSERT_DLY2(a_key_to_output, clk, rst_n, in_valid && !in_stall, out_valid, "no round key after key accepted")

  // no bubble inside a run once a round key is taken
  `AESKX_ASSERT_NEXT(a_no_bubble, clk, rst_n, out_valid && !out_stall && !out_last_round, out_valid, "gap between round keys")

  // no new key accepted early in a run
  `AESKX_ASSERT_IMPL(a_no_early_accept, clk, rst_n, out_valid && (out_round_number < aeskx_pkg::ROUND_COUNT - 4'd1), in_stall, "key accepted mid-run")

endmodule

[test/aes128_key_expansion_unit_tb.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// aes128_key_expansion_unit_tb
// Self-checking bench for the AES-128 key schedule unit. A table of directed
// cipher keys runs first, a few with round keys typed in, then random keys.
// Every key yields ten round-key words, checked field by field against a local
// schedule predictor. Random gaps and stalls fall on both channels.
// -----------------------------------------------------------------------------
module aes128_key_expansion_unit_tb;

  localparam int  DIRECTED_ROWS = 15;
  localparam int  RANDOM_KEYS   = 415;
  localparam int  SETTLE_CYCLES = 20;
  localparam int  CYCLE_LIMIT   = 1_000_000;
  localparam int  KEY_W         = aeskx_pkg::HALF_W;

  // one expected round-key word
  typedef struct packed {
    aeskx_pkg::round_t round;
    logic [KEY_W-1:0]  hi;
    logic [KEY_W-1:0]  lo;
    logic              last;
  } round_key_t;

  // one row of the directed table; known_r1 / known_r10 select typed-in keys
  typedef struct packed {
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] lo;
    logic             known_r1;
    logic [127:0]     r1;
    logic             known_r10;
    logic [127:0]     r10;
  } key_vector_t;

  logic clk;
  logic rst_n = 1'b0;

  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [KEY_W-1:0] in_key_hi = '0;
  logic [KEY_W-1:0] in_key_lo = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  aeskx_pkg::round_t      out_round_number;
  logic [KEY_W-1:0]       out_round_key_hi;
  logic [KEY_W-1:0]       out_round_key_lo;
  logic                   out_last_round;

  round_key_t  pending_round_keys[$];   // oldest first
  key_vector_t key_table [0:DIRECTED_ROWS-1];
  int          mismatches  = 0;
  int          cycle_count = 0;
  int          stall_left  = 0;
  bit          steady      = 1'b0;      // no gaps or stalls on either side while set

  aes128_key_expansion_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_hi        (in_key_hi),
    .in_key_lo        (in_key_lo),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_round_number (out_round_number),
    .out_round_key_hi (out_round_key_hi),
    .out_round_key_lo (out_round_key_lo),
    .out_last_round   (out_last_round)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Schedule predictor
  // ---------------------------------------------------------------------------

  // GF(2^8) product modulo x^8 + x^4 + x^3 + x + 1
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // S-box from first principles: multiplicative inverse (a^254, 0 maps to 0),
  // then the affine map
  function automatic logic [7:0] sbox_byte(input logic [7:0] a);
    logic [7:0] inv;
    logic [7:0] base;
    inv  = 8'h01;
    base = a;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) inv = gf_mul(inv, base);   // 254 = all exponent bits but bit 0
      base = gf_mul(base, base);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
               ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  // Expand one cipher key and queue its ten round keys. Typed-in round 1 / 10
  // values from the directed table take the place of the computed ones.
  task automatic queue_round_keys(input logic [KEY_W-1:0] hi, input logic [KEY_W-1:0] lo,
                                  input logic known_r1, input logic [127:0] r1,
                                  input logic known_r10, input logic [127:0] r10);
    logic [31:0] w [0:3];
    logic [31:0] mix;
    logic [7:0]  rc;
    round_key_t  rk;
    w[0] = hi[63:32];
    w[1] = hi[31:0];
    w[2] = lo[63:32];
    w[3] = lo[31:0];
    rc   = 8'h01;
    for (int r = 1; r <= 10; r++) begin
      // rotate left one byte, substitute, fold in the round constant
      mix  = {sbox_byte(w[3][23:16]), sbox_byte(w[3][15:8]),
              sbox_byte(w[3][7:0]),   sbox_byte(w[3][31:24])} ^ {rc, 24'h000000};
      w[0] = w[0] ^ mix;
      w[1] = w[1] ^ w[0];
      w[2] = w[2] ^ w[1];
      w[3] = w[3] ^ w[2];
      rc   = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      rk.round = aeskx_pkg::round_t'(r);
      rk.hi    = {w[0], w[1]};
      rk.lo    = {w[2], w[3]};
      rk.last  = (rk.round == aeskx_pkg::ROUND_COUNT);
      if (r == 1 && known_r1) {rk.hi, rk.lo} = r1;
      if (r == 10 && known_r10) {rk.hi, rk.lo} = r10;
      pending_round_keys.push_back(rk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_round_key();
    round_key_t want;
    if (pending_round_keys.size() == 0) begin
      report_mismatch($sformatf("round key word with nothing pending (round %0d)",
                                out_round_number));
      return;
    end
    want = pending_round_keys.pop_front();
    if (out_round_number !== want.round)
      report_mismatch($sformatf("round_number %0d, want %0d", out_round_number, want.round));
    if (out_round_key_hi !== want.hi)
      report_mismatch($sformatf("round %0d key_hi %h, want %h",
                                want.round, out_round_key_hi, want.hi));
    if (out_round_key_lo !== want.lo)
      report_mismatch($sformatf("round %0d key_lo %h, want %h",
                                want.round, out_round_key_lo, want.lo));
    if (out_last_round !== want.last)
      report_mismatch($sformatf("round %0d last_round %b, want %b",
                                want.round, out_last_round, want.last));
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick < 9)  return 0;
    if (pick < 13) return $urandom_range(1, 3);
    if (pick < 15) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Result side: check on every accepted word, then pick the next stall.
  // Stalls run regardless of out_valid so they land on every phase of a key.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_round_key();
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= steady ? 0 : random_gap();
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Present one key word and hold it until taken; expectations are queued at
  // the edge that takes it.
  task automatic send_key(input logic [KEY_W-1:0] hi, input logic [KEY_W-1:0] lo,
                          input logic known_r1, input logic [127:0] r1,
                          input logic known_r10, input logic [127:0] r10);
    int gap;
    gap = steady ? 0 : random_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_key_hi <= hi;
    in_key_lo <= lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    queue_round_keys(hi, lo, known_r1, r1, known_r10, r10);
  endtask

  // hold off the key side until every queued round key has come back
  task automatic drain_round_keys();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_round_keys.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] random_half();
    logic [KEY_W-1:0] v;
    logic [7:0]       b;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      6: v = v & {$urandom, $urandom} & {$urandom, $urandom};  // sparse
      7: v = v | {$urandom, $urandom} | {$urandom, $urandom};  // dense
      8: begin                                                  // one byte repeated
        b = 8'($urandom);
        v = {8{b}};
      end
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] lo;

    // Directed keys. Typed-in round keys: all-zero key, all-ones round 1 and
    // the two published FIPS-197 example keys.
    key_table[0]  = '{64'h0000000000000000, 64'h0000000000000000,
                      1'b1, 128'h62636363626363636263636362636363,
                      1'b1, 128'hb4ef5bcb3e92e21123e951cf6f8f188e};
    key_table[1]  = '{64'hffffffffffffffff, 64'hffffffffffffffff,
                      1'b1, 128'he8e9e9e917161616e8e9e9e917161616, 1'b0, 128'h0};
    key_table[2]  = '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
                      1'b1, 128'ha0fafe1788542cb123a339392a6c7605,
                      1'b1, 128'hd014f9a8c9ee2589e13f0cc8b6630ca6};
    key_table[3]  = '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                      1'b1, 128'hd6aa74fdd2af72fadaa678f1d6ab76fe,
                      1'b1, 128'h13111d7fe3944a17f307a78b4d2b30c5};
    key_table[4]  = '{64'hffffffffffffffff, 64'h0000000000000000, 1'b0, 128'h0, 1'b0, 128'h0};
    key_table[5]  = '{64'h0000000000000000, 64'hffffffffffffffff, 1'b0, 128'h0, 1'b0, 128'h0};
    key_table[6]  = '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 128'h0, 1'b0, 128'h0};
    key_table[7]  = '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 128'h0, 1'b0, 128'h0};
    key_table[8]  = '{64'h8000000000000000, 64'h0000000000000000, 1'b0, 128'h0, 1'b0, 128'h0};
    key_table[9]  = '{64'h0000000000000000, 64'h0000000000000001, 1'b0, 128'h0, 1'b0, 128'h0};
    key_table[10] = '{64'h0000000000000000, 64'h8000000000000000, 1'b0, 128'h0, 1'b0, 128'h0};
    key_table[11] = '{64'hffffffff00000000, 64'h00000000ffffffff, 1'b0, 128'h0, 1'b0, 128'h0};
    key_table[12] = '{64'h0000000000000000, 64'h00000000ffffffff, 1'b0, 128'h0, 1'b0, 128'h0};
    key_table[13] = '{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 128'h0, 1'b0, 128'h0};
    key_table[14] = '{64'h7f7f7f7f7f7f7f7f, 64'hfefefefefefefefe, 1'b0, 128'h0, 1'b0, 128'h0};

    // hold reset, then release it at an edge
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (key_table[i])
      send_key(key_table[i].hi, key_table[i].lo, key_table[i].known_r1, key_table[i].r1,
               key_table[i].known_r10, key_table[i].r10);

    // let the directed part finish before random traffic starts
    drain_round_keys();

    hi = random_half();
    lo = random_half();
    for (int n = 0; n < RANDOM_KEYS; n++) begin
      steady = (n >= 100 && n < 160);            // one stretch at full rate
      if (n == 250) drain_round_keys();          // mid-run hold-off
      // now and then a near neighbor of the last key: one bit flipped
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) hi[$urandom_range(0, KEY_W-1)] ^= 1'b1;
        else                      lo[$urandom_range(0, KEY_W-1)] ^= 1'b1;
      end else begin
        hi = random_half();
        lo = random_half();
      end
      send_key(hi, lo, 1'b0, 128'h0, 1'b0, 128'h0);
    end
    steady = 1'b0;

    drain_round_keys();
    // catch any stray words after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/aeskx_pkg.sv
hdl/aeskx_datapath.sv
hdl/aeskx_ctrl.sv
hdl/aes128_key_expansion_unit.sv
test/aes128_key_expansion_unit_tb.sv
